/* rtl/oled_page_framebuffer_assert.svh */
// Assertion macros used by the framebuffer top level.
`ifndef OLED_PAGE_FRAMEBUFFER_ASSERT_SVH
`define OLED_PAGE_FRAMEBUFFER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define OFB_ASSERT_SAME(label, c, r, ante, cons) \
    label: assert property (@(posedge c) disable iff (!r) (ante) |-> (cons)) \
        else $error("ofb: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define OFB_ASSERT_NEXT(label, c, r, ante, cons) \
    label: assert property (@(posedge c) disable iff (!r) (ante) |=> (cons)) \
        else $error("ofb: next-cycle check failed");

`endif

/* rtl/ofb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ofb_pkg
// Types, constants and codes of the page-organized OLED frame store.
// ----------------------------------------------------------------------------
package ofb_pkg;

    localparam int COLUMNS    = 128;
    localparam int PAGES      = 8;
    localparam int ROWS       = PAGES * 8;
    localparam int COL_W      = $clog2(COLUMNS);
    localparam int ROW_W      = $clog2(ROWS);
    localparam int PAGE_W     = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int SLOT_W     = $clog2(COLUMNS + 3);
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // panel stream command bytes
    localparam logic [7:0] PAGE_CMD_BASE = 8'hB0;
    localparam logic [7:0] COL_LOW_CMD   = 8'h00;
    localparam logic [7:0] COL_HIGH_CMD  = 8'h10;

    // positions within one page of the refresh stream
    localparam int SLOT_PAGE   = 0;
    localparam int SLOT_COL_LO = 1;
    localparam int SLOT_COL_HI = 2;
    localparam int SLOT_DATA0  = 3;

    typedef enum logic [2:0] {
        CMD_POINT     = 3'd0,
        CMD_PIC_START = 3'd1,
        CMD_PIC_BYTE  = 3'd2,
        CMD_CLEAR     = 3'd3,
        CMD_REFRESH   = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        OP_WRITE    = 2'd0,
        OP_CLEAR    = 2'd1,
        OP_CMD_BYTE = 2'd2,
        OP_DATA     = 2'd3
    } op_kind_t;

    typedef enum logic [1:0] {
        BK_IDLE   = 2'd0,
        BK_MODIFY = 2'd1,
        BK_EMIT   = 2'd2
    } back_state_t;

    typedef struct packed {
        logic [2:0] cmd;
        logic [6:0] x;
        logic [5:0] y;
        logic [7:0] pic_width;
        logic [6:0] pic_height;
        logic [7:0] bits;
        logic       mode;
    } req_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_data;
        logic       frame_end;
    } res_t;

    // work item passed from the front to the back
    typedef struct packed {
        op_kind_t          kind;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic [7:0]        value;   // pixel bits, or the command byte
        logic [7:0]        mask;
        logic [PAGE_W-1:0] page;
        logic              last;
    } op_t;

    typedef struct packed {
        logic busy;
    } back_status_t;

endpackage

/* rtl/ofb_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ofb_front
// Accepts requests, tracks the picture cursor and refresh position, and
// turns each request into at most one store operation.
// ----------------------------------------------------------------------------
module ofb_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    input  ofb_pkg::req_t req,
    input  logic          fifo_full,
    output logic          push,
    output ofb_pkg::op_t  op
);

    logic [6:0]                 pic_origin_x_reg, pic_origin_x_next;
    logic [6:0]                 pic_row_reg, pic_row_next;
    logic [7:0]                 pic_column_reg, pic_column_next;
    logic [7:0]                 pic_cols_reg, pic_cols_next;
    logic [3:0]                 pic_bands_reg, pic_bands_next;
    logic                       pic_mode_reg, pic_mode_next;
    logic [ofb_pkg::PAGE_W-1:0] refresh_page_reg, refresh_page_next;
    logic [ofb_pkg::SLOT_W-1:0] refresh_slot_reg, refresh_slot_next;

    logic       accept;
    logic       point_ok;
    logic [8:0] col_sum;
    logic       pic_ok;
    logic [7:0] column_inc;
    logic [7:0] row_step;
    logic [6:0] row_sat;
    logic [7:0] band_sum;
    logic [4:0] bands_raw;
    logic [3:0] bands;
    logic       slot_last;
    logic       page_last;

    assign accept     = req_valid && !fifo_full;
    assign point_ok   = (9'(req.x) < 9'(ofb_pkg::COLUMNS)) && (7'(req.y) < 7'(ofb_pkg::ROWS));
    assign col_sum    = 9'(pic_origin_x_reg) + 9'(pic_column_reg);
    assign pic_ok     = (col_sum < 9'(ofb_pkg::COLUMNS)) && (pic_row_reg < 7'(ofb_pkg::ROWS));
    assign column_inc = pic_column_reg + 8'd1;
    assign row_step   = 8'(pic_row_reg) + 8'd8;
    assign row_sat    = (row_step > 8'd127) ? 7'd127 : row_step[6:0];
    assign band_sum   = 8'(req.pic_height) + 8'd7;
    assign bands_raw  = band_sum[7:3];
    assign bands      = (req.pic_width == 8'd0) ? 4'd0 :
                        (bands_raw > 5'd15)     ? 4'd15 : bands_raw[3:0];
    assign slot_last  = refresh_slot_reg == ofb_pkg::SLOT_W'(ofb_pkg::COLUMNS + 2);
    assign page_last  = refresh_page_reg == ofb_pkg::PAGE_W'(ofb_pkg::PAGES - 1);

    always_comb
    begin
        pic_origin_x_next = pic_origin_x_reg;
        pic_row_next      = pic_row_reg;
        pic_column_next   = pic_column_reg;
        pic_cols_next     = pic_cols_reg;
        pic_bands_next    = pic_bands_reg;
        pic_mode_next     = pic_mode_reg;
        refresh_page_next = refresh_page_reg;
        refresh_slot_next = refresh_slot_reg;
        push              = 1'b0;
        op                = '0;
        if (accept)
        begin
            unique case (req.cmd)
                ofb_pkg::CMD_POINT:
                begin
                    op.kind  = ofb_pkg::OP_WRITE;
                    op.col   = ofb_pkg::COL_W'(req.x);
                    op.row   = ofb_pkg::ROW_W'(req.y);
                    op.value = {7'd0, req.mode};
                    op.mask  = 8'h01;
                    push     = point_ok;
                end
                ofb_pkg::CMD_PIC_START:
                begin
                    pic_origin_x_next = req.x;
                    pic_row_next      = 7'(req.y);
                    pic_column_next   = 8'd0;
                    pic_cols_next     = req.pic_width;
                    pic_bands_next    = bands;
                    pic_mode_next     = req.mode;
                end
                ofb_pkg::CMD_PIC_BYTE:
                begin
                    if (pic_bands_reg != 4'd0)
                    begin
                        // rows past the bottom fall off in the back's shift
                        op.kind  = ofb_pkg::OP_WRITE;
                        op.col   = ofb_pkg::COL_W'(col_sum);
                        op.row   = ofb_pkg::ROW_W'(pic_row_reg);
                        op.value = pic_mode_reg ? req.bits : ~req.bits;
                        op.mask  = 8'hFF;
                        push     = pic_ok;
                        if (column_inc == pic_cols_reg)
                        begin
                            pic_column_next = 8'd0;
                            pic_row_next    = row_sat;
                            pic_bands_next  = pic_bands_reg - 4'd1;
                        end
                        else
                        begin
                            pic_column_next = column_inc;
                        end
                    end
                end
                ofb_pkg::CMD_CLEAR:
                begin
                    op.kind = ofb_pkg::OP_CLEAR;
                    push    = 1'b1;
                end
                ofb_pkg::CMD_REFRESH:
                begin
                    push = 1'b1;
                    priority if (refresh_slot_reg == ofb_pkg::SLOT_W'(ofb_pkg::SLOT_PAGE))
                    begin
                        op.kind  = ofb_pkg::OP_CMD_BYTE;
                        op.value = ofb_pkg::PAGE_CMD_BASE + 8'(refresh_page_reg);
                    end
                    else if (refresh_slot_reg == ofb_pkg::SLOT_W'(ofb_pkg::SLOT_COL_LO))
                    begin
                        op.kind  = ofb_pkg::OP_CMD_BYTE;
                        op.value = ofb_pkg::COL_LOW_CMD;
                    end
                    else if (refresh_slot_reg == ofb_pkg::SLOT_W'(ofb_pkg::SLOT_COL_HI))
                    begin
                        op.kind  = ofb_pkg::OP_CMD_BYTE;
                        op.value = ofb_pkg::COL_HIGH_CMD;
                    end
                    else
                    begin
                        op.kind = ofb_pkg::OP_DATA;
                        op.col  = ofb_pkg::COL_W'(refresh_slot_reg
                                  - ofb_pkg::SLOT_W'(ofb_pkg::SLOT_DATA0));
                        op.page = refresh_page_reg;
                        op.last = slot_last && page_last;
                    end
                    if (slot_last)
                    begin
                        refresh_slot_next = '0;
                        refresh_page_next = page_last ? '0 : refresh_page_reg + 1'b1;
                    end
                    else
                    begin
                        refresh_slot_next = refresh_slot_reg + 1'b1;
                    end
                end
                default:
                begin
                    push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pic_origin_x_reg <= '0;
            pic_row_reg      <= '0;
            pic_column_reg   <= '0;
            pic_cols_reg     <= '0;
            pic_bands_reg    <= '0;
            pic_mode_reg     <= 1'b1;
            refresh_page_reg <= '0;
            refresh_slot_reg <= '0;
        end
        else
        begin
            pic_origin_x_reg <= pic_origin_x_next;
            pic_row_reg      <= pic_row_next;
            pic_column_reg   <= pic_column_next;
            pic_cols_reg     <= pic_cols_next;
            pic_bands_reg    <= pic_bands_next;
            pic_mode_reg     <= pic_mode_next;
            refresh_page_reg <= refresh_page_next;
            refresh_slot_reg <= refresh_slot_next;
        end
    end

endmodule

/* rtl/ofb_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ofb_fifo
// Short queue of store operations between the front and the back.
// ----------------------------------------------------------------------------
module ofb_fifo (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  ofb_pkg::op_t push_op,
    input  logic         pop,
    output ofb_pkg::op_t head,
    output logic         full,
    output logic         empty
);

    ofb_pkg::op_t                   slot_reg [ofb_pkg::FIFO_DEPTH];
    logic [ofb_pkg::FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [ofb_pkg::FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [ofb_pkg::FIFO_CNT_W-1:0] count_reg, count_next;

    localparam logic [ofb_pkg::FIFO_PTR_W-1:0] PTR_LAST =
        ofb_pkg::FIFO_PTR_W'(ofb_pkg::FIFO_DEPTH - 1);

    assign full  = count_reg == ofb_pkg::FIFO_CNT_W'(ofb_pkg::FIFO_DEPTH);
    assign empty = count_reg == '0;
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

/* rtl/ofb_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ofb_back
// Executes store operations on the column memory and drives the output
// register of the panel stream.
// ----------------------------------------------------------------------------
module ofb_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ofb_pkg::op_t          head,
    input  logic                  fifo_empty,
    output logic                  pop,
    input  logic                  stream_stall,
    output logic                  stream_valid,
    output ofb_pkg::res_t         stream,
    output ofb_pkg::back_status_t status
);

    ofb_pkg::back_state_t state_reg, state_next;
    ofb_pkg::op_t         op_reg;

    logic [ofb_pkg::ROWS-1:0]    mem [ofb_pkg::COLUMNS];
    logic [ofb_pkg::ROWS-1:0]    rd_data_reg;
    logic                        rd_valid_reg;
    logic [ofb_pkg::COLUMNS-1:0] valid_reg, valid_next;

    logic                     out_valid_reg, out_valid_next;
    ofb_pkg::res_t            out_reg, out_next;
    logic                     out_free;
    logic                     out_load;
    logic                     rd_en;
    logic                     wr_en;
    logic                     clear_all;
    logic [ofb_pkg::ROWS-1:0] old_word;
    logic [ofb_pkg::ROWS-1:0] wr_mask;
    logic [ofb_pkg::ROWS-1:0] wr_bits;
    logic [ofb_pkg::ROWS-1:0] new_word;
    logic [7:0]               data_byte;

    assign out_free     = !out_valid_reg || !stream_stall;
    assign stream_valid = out_valid_reg;
    assign stream       = out_reg;
    assign status.busy  = state_reg != ofb_pkg::BK_IDLE;

    // a column never written since the last clear reads as blank
    assign old_word  = rd_valid_reg ? rd_data_reg : '0;
    assign wr_mask   = ofb_pkg::ROWS'(op_reg.mask) << op_reg.row;
    assign wr_bits   = ofb_pkg::ROWS'(op_reg.value & op_reg.mask) << op_reg.row;
    assign new_word  = (old_word & ~wr_mask) | wr_bits;
    assign data_byte = old_word[{op_reg.page, 3'b000} +: 8];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ofb_pkg::BK_IDLE:
            begin
                if (!fifo_empty)
                begin
                    unique case (head.kind)
                        ofb_pkg::OP_WRITE: state_next = ofb_pkg::BK_MODIFY;
                        ofb_pkg::OP_DATA:  state_next = ofb_pkg::BK_EMIT;
                        default:           state_next = ofb_pkg::BK_IDLE;
                    endcase
                end
            end
            ofb_pkg::BK_MODIFY:
            begin
                state_next = ofb_pkg::BK_IDLE;
            end
            ofb_pkg::BK_EMIT:
            begin
                if (out_free)
                begin
                    state_next = ofb_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = ofb_pkg::BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pop       = 1'b0;
        rd_en     = 1'b0;
        wr_en     = 1'b0;
        clear_all = 1'b0;
        out_load  = 1'b0;
        out_next  = out_reg;
        unique case (state_reg)
            ofb_pkg::BK_IDLE:
            begin
                if (!fifo_empty)
                begin
                    unique case (head.kind)
                        ofb_pkg::OP_WRITE,
                        ofb_pkg::OP_DATA:
                        begin
                            pop   = 1'b1;
                            rd_en = 1'b1;
                        end
                        ofb_pkg::OP_CLEAR:
                        begin
                            pop       = 1'b1;
                            clear_all = 1'b1;
                        end
                        ofb_pkg::OP_CMD_BYTE:
                        begin
                            if (out_free)
                            begin
                                pop                = 1'b1;
                                out_load           = 1'b1;
                                out_next.out_byte  = head.value;
                                out_next.is_data   = 1'b0;
                                out_next.frame_end = 1'b0;
                            end
                        end
                        default:
                        begin
                            pop = 1'b0;
                        end
                    endcase
                end
            end
            ofb_pkg::BK_MODIFY:
            begin
                wr_en = 1'b1;
            end
            ofb_pkg::BK_EMIT:
            begin
                if (out_free)
                begin
                    out_load           = 1'b1;
                    out_next.out_byte  = data_byte;
                    out_next.is_data   = 1'b1;
                    out_next.frame_end = op_reg.last;
                end
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (clear_all)
        begin
            valid_next = '0;
        end
        else if (wr_en)
        begin
            valid_next[op_reg.col] = 1'b1;
        end
    end

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && stream_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ofb_pkg::BK_IDLE;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            op_reg <= head;
        end
        if (out_load)
        begin
            out_reg <= out_next;
        end
        if (rd_en)
        begin
            rd_valid_reg <= valid_reg[head.col];
        end
    end

    // column memory: one read or one write per cycle, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[op_reg.col] <= new_word;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[head.col];
        end
    end

endmodule

/* rtl/oled_page_framebuffer.sv */
`timescale 1ns / 1ps
`include "oled_page_framebuffer_assert.svh"
// ----------------------------------------------------------------------------
// oled_page_framebuffer
// 128 x 64 monochrome page-mode frame store with panel refresh stream.
// ----------------------------------------------------------------------------
// A request is taken in any cycle in which the four-entry operation queue has
// room; the front handles picture and refresh bookkeeping in that cycle. The
// back reads the column word and then writes it or loads the output for a
// point, a picture byte or a refresh data byte, through the one port of the
// column memory; a refresh command byte or a clear (via per-column valid
// bits) it handles straight from idle. A request that touches nothing is not
// queued. The front keeps taking requests while the back works; the back
// takes a new operation only when idle, and stream stalls hold it back.
module oled_page_framebuffer (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          draw_valid,
    output logic          draw_stall,
    input  ofb_pkg::req_t draw,
    output logic          stream_valid,
    input  logic          stream_stall,
    output ofb_pkg::res_t stream
);

    logic                  push;
    logic                  pop;
    logic                  fifo_full;
    logic                  fifo_empty;
    ofb_pkg::op_t          push_op;
    ofb_pkg::op_t          head;
    ofb_pkg::back_status_t back_status;

    assign draw_stall = fifo_full;

    ofb_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (draw_valid),
        .req       (draw),
        .fifo_full (fifo_full),
        .push      (push),
        .op        (push_op)
    );

    ofb_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .pop     (pop),
        .head    (head),
        .full    (fifo_full),
        .empty   (fifo_empty)
    );

    ofb_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .fifo_empty   (fifo_empty),
        .pop          (pop),
        .stream_stall (stream_stall),
        .stream_valid (stream_valid),
        .stream       (stream),
        .status       (back_status)
    );

    `OFB_ASSERT_SAME(a_pop_has_item, clk, rst_n, pop, !fifo_empty)
    `OFB_ASSERT_SAME(a_queue_count_sane, clk, rst_n, fifo_full, !fifo_empty)
    `OFB_ASSERT_NEXT(a_out_from_back, clk, rst_n, !stream_valid && !pop && !back_status.busy, !stream_valid)

endmodule
